// ===== rtl/ert_pkg.sv =====
// Shared constants, CORDIC arctangent table and helper types for the rotation block.
`default_nettype none
package ert_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned TrigFrac    = 15;
  localparam int unsigned PhaseWidth  = 32;
  localparam int unsigned CordicWidth = 34;
  localparam int unsigned TrigWidth   = 17;

  localparam logic [CordicWidth-1:0] CordicGain = 34'sd652032874;

  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;

  typedef struct packed {
    logic signed [TrigWidth-1:0] c;
    logic signed [TrigWidth-1:0] s;
    logic                        skip;
  } trig_t;

  function automatic logic signed [CordicWidth-1:0] atan_phase(input logic [4:0] i);
    logic signed [CordicWidth-1:0] r;
    case (i)
      5'd0:  r = 34'sh020000000;
      5'd1:  r = 34'sh012E4051E;
      5'd2:  r = 34'sh009FB385B;
      5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43;
      5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E;
      5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53;
      5'd9:  r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98;
      5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6;
      5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA;
      5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE;
      5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30;
      5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C;
      5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3;
      5'd23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ert_cordic_cell.sv =====
// One CORDIC micro-rotation cell of the sine/cosine chain.
`default_nettype none
module ert_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire                                     clk_i,
  input  wire logic signed [ert_pkg::CordicWidth-1:0] x_i,
  input  wire logic signed [ert_pkg::CordicWidth-1:0] y_i,
  input  wire logic signed [ert_pkg::CordicWidth-1:0] z_i,
  output logic signed [ert_pkg::CordicWidth-1:0]      x_o,
  output logic signed [ert_pkg::CordicWidth-1:0]      y_o,
  output logic signed [ert_pkg::CordicWidth-1:0]      z_o
);

  logic signed [ert_pkg::CordicWidth-1:0] dx, dy, at;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;
  assign at = ert_pkg::atan_phase(5'(STEP));

  always_ff @(posedge clk_i) begin
    if (!z_i[ert_pkg::CordicWidth-1]) begin
      x_o <= x_i - dx;
      y_o <= y_i + dy;
      z_o <= z_i - at;
    end else begin
      x_o <= x_i + dx;
      y_o <= y_i - dy;
      z_o <= z_i + at;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ert_trig.sv =====
// Sine/cosine of a configured angle: chain of CORDIC cells, rounding and quadrant map.
`default_nettype none
module ert_trig #(
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  wire                    clk_i,
  input  wire [ANGLE_WIDTH-1:0]  angle_i,
  output ert_pkg::trig_t         trig_o
);

  localparam int unsigned N = ert_pkg::CordicSteps;
  localparam int unsigned W = ert_pkg::CordicWidth;

  logic [ert_pkg::PhaseWidth-1:0] phase;
  logic signed [W-1:0] xs [N+1];
  logic signed [W-1:0] ys [N+1];
  logic signed [W-1:0] zs [N+1];
  logic [N-1:0][1:0] quad_q;
  logic [N-1:0]      skip_q;
  logic signed [ert_pkg::TrigWidth-1:0] cc, ss;

  assign phase = {angle_i, {(ert_pkg::PhaseWidth-ANGLE_WIDTH){1'b0}}};
  assign xs[0] = ert_pkg::CordicGain;
  assign ys[0] = '0;
  assign zs[0] = W'({2'b00, phase[ert_pkg::PhaseWidth-3:0]});

  for (genvar i = 0; i < N; i++) begin : g_cell
    ert_cordic_cell #(.STEP(i)) u_cell (
      .clk_i (clk_i),
      .x_i   (xs[i]), .y_i(ys[i]), .z_i(zs[i]),
      .x_o   (xs[i+1]), .y_o(ys[i+1]), .z_o(zs[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    quad_q <= {quad_q[N-2:0], phase[ert_pkg::PhaseWidth-1 -: 2]};
    skip_q <= {skip_q[N-2:0], (angle_i == '0)};
  end

  function automatic logic signed [ert_pkg::TrigWidth-1:0] to_q15(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = (v + W'(1 << 14)) >>> 15;
    if (r > W'(32768)) r = W'(32768);
    if (r < -W'(32768)) r = -W'(32768);
    return r[ert_pkg::TrigWidth-1:0];
  endfunction

  assign cc = to_q15(xs[N]);
  assign ss = to_q15(ys[N]);

  always_ff @(posedge clk_i) begin
    trig_o.skip <= skip_q[N-1];
    case (quad_q[N-1])
      2'd0: begin trig_o.c <= cc;  trig_o.s <= ss;  end
      2'd1: begin trig_o.c <= -ss; trig_o.s <= cc;  end
      2'd2: begin trig_o.c <= -cc; trig_o.s <= -ss; end
      default: begin trig_o.c <= ss; trig_o.s <= -cc; end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ert_rot_cell.sv =====
// One plane rotation cell: a' = c*a - s*b, b' = s*a + c*b, two stages, rounded and saturated.
`default_nettype none
module ert_rot_cell #(
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input  wire                              clk_i,
  input  wire                              en_i,
  input  ert_pkg::trig_t                   trig_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] a_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] b_i,
  output logic signed [COMPONENT_WIDTH-1:0]      a_o,
  output logic signed [COMPONENT_WIDTH-1:0]      b_o
);

  localparam int unsigned PW = COMPONENT_WIDTH + ert_pkg::TrigWidth;
  localparam int unsigned SW = PW + 1;

  logic signed [PW-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [COMPONENT_WIDTH-1:0] a_q, b_q;
  logic skip_q;
  logic signed [SW-1:0] sum_a, sum_b;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q   <= PW'(trig_i.c) * PW'(a_i);
      sb_q   <= PW'(trig_i.s) * PW'(b_i);
      sa_q   <= PW'(trig_i.s) * PW'(a_i);
      cb_q   <= PW'(trig_i.c) * PW'(b_i);
      a_q    <= a_i;
      b_q    <= b_i;
      skip_q <= trig_i.skip;
    end
  end

  function automatic logic signed [COMPONENT_WIDTH-1:0] rnd_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] hi, lo;
    hi = SW'({1'b0, {(COMPONENT_WIDTH-1){1'b1}}});
    lo = ~hi;
    r = (v + SW'(1 << (ert_pkg::TrigFrac-1))) >>> ert_pkg::TrigFrac;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[COMPONENT_WIDTH-1:0];
  endfunction

  assign sum_a = SW'(ca_q) - SW'(sb_q);
  assign sum_b = SW'(sa_q) + SW'(cb_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= skip_q ? a_q : rnd_sat(sum_a);
      b_o <= skip_q ? b_q : rnd_sat(sum_b);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/euler_rotate_xyz_pair.sv =====
// Top level: rotates a ray direction and origin about X, then Y, then Z.
//   channel | dir | beat contents
//   s_axis  | in  | dir_x, dir_y, dir_z, org_x, org_y, org_z
//   m_axis  | out | rot_dir_x .. rot_org_z
//   cfg     | in  | angle_x, angle_y, angle_z (index 0..2)
// One beat per cycle unless the output stalls or the pipes settle (three axis cells of two stages each).
// Sine/cosine pipes follow the angle registers; s_axis_tready is held low after reset and
// after each write while they settle.
// The pipeline advances whenever the output stage is empty or being taken.
// Reset clears valid flags and angles and reloads the settle count only.
`default_nettype none
module euler_rotate_xyz_pair #(
  parameter int unsigned COMPONENT_WIDTH = 32,
  parameter int unsigned ANGLE_WIDTH     = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // dir_x, dir_y, dir_z, org_x, org_y, org_z from bit 0 up
  input  wire [6*COMPONENT_WIDTH-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // rot_dir_x, rot_dir_y, rot_dir_z, rot_org_x, rot_org_y, rot_org_z from bit 0 up
  output logic [6*COMPONENT_WIDTH-1:0] m_axis_tdata,
  input  wire                          cfg_we_i,
  input  wire [1:0]                    cfg_idx_i,
  input  wire [ANGLE_WIDTH-1:0]        cfg_data_i
);

  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned Lat = 6;
  localparam int unsigned TrigLat = ert_pkg::CordicSteps + 1;

  logic [ANGLE_WIDTH-1:0] ang_q [3];
  ert_pkg::trig_t trig [3];
  logic [Lat-1:0] vld_q;
  logic [4:0] settle_q;
  logic en;
  logic signed [CW-1:0] v [4][6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q[0] <= '0; ang_q[1] <= '0; ang_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ert_pkg::REG_ANGLE_X: ang_q[0] <= cfg_data_i;
        ert_pkg::REG_ANGLE_Y: ang_q[1] <= cfg_data_i;
        ert_pkg::REG_ANGLE_Z: ang_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 5'(TrigLat);
    end else if (cfg_we_i) begin
      settle_q <= 5'(TrigLat);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 5'd1;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_trig
    ert_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig (
      .clk_i(clk_i), .angle_i(ang_q[a]), .trig_o(trig[a])
    );
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && (settle_q == '0);
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid && s_axis_tready};
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_in
    assign v[0][k] = s_axis_tdata[k*CW +: CW];
    assign m_axis_tdata[k*CW +: CW] = v[3][k];
  end

  for (genvar p = 0; p < 2; p++) begin : g_vec
    // X: (y, z)
    ert_rot_cell #(.COMPONENT_WIDTH(CW)) u_x (
      .clk_i(clk_i), .en_i(en), .trig_i(trig[0]),
      .a_i(v[0][3*p+1]), .b_i(v[0][3*p+2]), .a_o(v[1][3*p+1]), .b_o(v[1][3*p+2])
    );
    logic signed [CW-1:0] x0_q, x0b_q;
    always_ff @(posedge clk_i) if (en) begin x0_q <= v[0][3*p]; x0b_q <= x0_q; end
    assign v[1][3*p] = x0b_q;
    // Y: (z, x)
    ert_rot_cell #(.COMPONENT_WIDTH(CW)) u_y (
      .clk_i(clk_i), .en_i(en), .trig_i(trig[1]),
      .a_i(v[1][3*p+2]), .b_i(v[1][3*p]), .a_o(v[2][3*p+2]), .b_o(v[2][3*p])
    );
    logic signed [CW-1:0] y1_q, y1b_q;
    always_ff @(posedge clk_i) if (en) begin y1_q <= v[1][3*p+1]; y1b_q <= y1_q; end
    assign v[2][3*p+1] = y1b_q;
    // Z: (x, y)
    ert_rot_cell #(.COMPONENT_WIDTH(CW)) u_z (
      .clk_i(clk_i), .en_i(en), .trig_i(trig[2]),
      .a_i(v[2][3*p]), .b_i(v[2][3*p+1]), .a_o(v[3][3*p]), .b_o(v[3][3*p+1])
    );
    logic signed [CW-1:0] z2_q, z2b_q;
    always_ff @(posedge clk_i) if (en) begin z2_q <= v[2][3*p+2]; z2b_q <= z2_q; end
    assign v[3][3*p+2] = z2b_q;
  end

endmodule
`default_nettype wire
